// ===== rtl/sai_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_pkg
// Shared types and codes for the sorted insertion store.
// ----------------------------------------------------------------------------
package sai_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 8;
  localparam int unsigned OutW   = 9;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic                     capture;
    logic                     shift;
    logic signed [ValueW-1:0] cmp_value;
    logic signed [ValueW-1:0] ins_value;
  } cell_ctrl_t;

endpackage

// ===== rtl/sai_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_cell
// One slot of the sorted chain: holds an entry, compares it against the
// incoming value and takes its lower neighbor's entry on a shifting insert.
// ----------------------------------------------------------------------------
module sai_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9
) (
  input  logic                                    clk_i,
  input  sai_pkg::cell_ctrl_t                     ctrl_i,
  input  logic [CW-1:0]                           count_i,
  input  logic [sai_pkg::IndexW-1:0]              index_i,
  input  logic                                    prev_lt_i,
  input  logic signed [sai_pkg::ValueW-1:0]       prev_entry_i,
  output logic signed [sai_pkg::ValueW-1:0]       entry_o,
  output logic                                    lt_o,
  output logic                                    bound_o,
  output logic signed [sai_pkg::ValueW-1:0]       rd_data_o
);

  logic signed [sai_pkg::ValueW-1:0] entry_q;
  logic                              lt_q;
  logic                              hit_q;
  logic                              occupied;

  assign occupied = (32'(IDX) < 32'(count_i));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      lt_q  <= occupied && (entry_q < ctrl_i.cmp_value);
      hit_q <= (32'(IDX) == 32'(index_i));
    end
  end

  // keep smaller entries, drop the new value at the boundary, shift the rest
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift && !lt_q) begin
      if (prev_lt_i) begin
        entry_q <= ctrl_i.ins_value;
      end else begin
        entry_q <= prev_entry_i;
      end
    end
  end

  assign entry_o   = entry_q;
  assign lt_o      = lt_q;
  assign bound_o   = !lt_q && prev_lt_i;
  assign rd_data_o = hit_q ? entry_q : '0;

endmodule

// ===== rtl/sorted_array_insert.sv =====
`timescale 1ns / 1ps
// Sequence: the compare is captured on input transfer, then the shift and the
// result register load when the item commits. One item at a time: input is
// stalled until the result is registered, and a result waiting in the output
// register stalls only the commit (shift and result) of the next item, not its compare.
// Reset: entry count cleared to zero at once; stored entries are undefined.
// ----------------------------------------------------------------------------
// sorted_array_insert
// Sorted store of signed values in a chain of cells with insert and read.
// ----------------------------------------------------------------------------
module sorted_array_insert #(
  parameter int unsigned SIZE = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic signed [sai_pkg::ValueW-1:0]   value_i,
  input  logic [sai_pkg::IndexW-1:0]          index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [sai_pkg::OutW-1:0]            position_o,
  output logic signed [sai_pkg::ValueW-1:0]   read_value_o,
  output logic [sai_pkg::OutW-1:0]            entry_count_o
);

  localparam int unsigned CW = $clog2(SIZE + 1);
  localparam int unsigned IW = $clog2(SIZE);

  sai_pkg::state_e state_q, state_d;

  logic                              act_q;
  logic signed [sai_pkg::ValueW-1:0] val_q;
  logic [sai_pkg::IndexW-1:0]        idx_q;
  logic [CW-1:0]                     count_q, count_d;

  logic                              out_valid_q;
  logic [1:0]                        status_q;
  logic [sai_pkg::OutW-1:0]          position_q;
  logic signed [sai_pkg::ValueW-1:0] rdval_q;
  logic [sai_pkg::OutW-1:0]          ecount_q;

  logic                              accept;
  logic                              commit;
  logic                              full;
  logic                              ins_ok;
  logic                              in_range;
  sai_pkg::cell_ctrl_t               ctrl;

  logic signed [sai_pkg::ValueW-1:0] ent  [SIZE];
  logic signed [sai_pkg::ValueW-1:0] rdd  [SIZE];
  logic [SIZE-1:0]                   lt;
  logic [SIZE-1:0]                   bnd;
  logic [IW-1:0]                     pos_c;
  logic signed [sai_pkg::ValueW-1:0] rd_c;

  logic [1:0]                        status_d;
  logic [sai_pkg::OutW-1:0]          position_d;
  logic signed [sai_pkg::ValueW-1:0] rdval_d;

  assign accept   = in_valid_i && !in_stall_o;
  assign full     = (count_q == CW'(SIZE));
  assign ins_ok   = (act_q == sai_pkg::ACT_INSERT) && !full;
  assign in_range = (32'(idx_q) < 32'(count_q));

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    commit     = 1'b0;
    unique case (state_q)
      sai_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = sai_pkg::S_EXEC;
        end
      end
      sai_pkg::S_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          commit  = 1'b1;
          state_d = sai_pkg::S_IDLE;
        end
      end
      default: state_d = sai_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sai_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      val_q <= value_i;
      idx_q <= index_i;
    end
  end

  assign ctrl.capture   = accept;
  assign ctrl.shift     = commit && ins_ok;
  assign ctrl.cmp_value = value_i;
  assign ctrl.ins_value = val_q;

  for (genvar i = 0; i < SIZE; i++) begin : g_cell
    logic                              prev_lt;
    logic signed [sai_pkg::ValueW-1:0] prev_entry;
    if (i == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_entry = '0;
    end else begin : g_rest
      assign prev_lt    = lt[i-1];
      assign prev_entry = ent[i-1];
    end
    sai_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .index_i      (index_i),
      .prev_lt_i    (prev_lt),
      .prev_entry_i (prev_entry),
      .entry_o      (ent[i]),
      .lt_o         (lt[i]),
      .bound_o      (bnd[i]),
      .rd_data_o    (rdd[i])
    );
  end

  always_comb begin
    pos_c = '0;
    rd_c  = '0;
    for (int i = 0; i < SIZE; i++) begin
      if (bnd[i]) begin
        pos_c = pos_c | IW'(i);
      end
      rd_c = rd_c | rdd[i];
    end
  end

  always_comb begin
    count_d    = count_q;
    status_d   = sai_pkg::ST_OK;
    position_d = '0;
    rdval_d    = '0;
    if (act_q == sai_pkg::ACT_INSERT) begin
      if (full) begin
        status_d = sai_pkg::ST_OVERFLOW;
      end else begin
        position_d = sai_pkg::OutW'(pos_c);
        count_d    = count_q + CW'(1);
      end
    end else begin
      position_d = sai_pkg::OutW'(idx_q);
      if (in_range) begin
        rdval_d = rd_c;
      end else begin
        status_d = sai_pkg::ST_RANGE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q   <= status_d;
      position_q <= position_d;
      rdval_q    <= rdval_d;
      ecount_q   <= sai_pkg::OutW'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign position_o    = position_q;
  assign read_value_o  = rdval_q;
  assign entry_count_o = ecount_q;

endmodule

// ===== rtl/sai_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_checker
// Port-level checks for the sorted insertion store, bound to the top level.
// ----------------------------------------------------------------------------
module sai_checker #(
  parameter int unsigned SIZE = 256
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [1:0]                          status_o,
  input logic [sai_pkg::OutW-1:0]            position_o,
  input logic signed [sai_pkg::ValueW-1:0]   read_value_o,
  input logic [sai_pkg::OutW-1:0]            entry_count_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one transfer in flight: stall right after input transfer
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == sai_pkg::ST_OK || status_o == sai_pkg::ST_OVERFLOW ||
                     status_o == sai_pkg::ST_RANGE))
    else $error("bad status code");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sai_pkg::ST_OVERFLOW |->
      position_o == '0 && read_value_o == '0 && 32'(entry_count_o) <= SIZE)
    else $error("overflow result malformed");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sai_pkg::ST_RANGE |->
      read_value_o == '0 && position_o >= entry_count_o)
    else $error("out of range result malformed");

endmodule

bind sorted_array_insert sai_checker #(
  .SIZE (SIZE)
) u_sai_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .position_o    (position_o),
  .read_value_o  (read_value_o),
  .entry_count_o (entry_count_o)
);
